### design/hmac_sha1_engine_top_macros.svh
// Assertion macros shared by the HMAC-SHA1 engine modules.
// Each use needs clk and rst_n in scope.
`ifndef HMAC_SHA1_ENGINE_TOP_MACROS_SVH
`define HMAC_SHA1_ENGINE_TOP_MACROS_SVH

// Same-cycle implication.
`define HSE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define HSE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/hse_pkg.sv
// Shared types, constants and codes for the HMAC-SHA1 engine.
// No dependencies.
package hse_pkg;

    localparam int LCB_DEFAULT = 32;
    localparam logic [7:0] IPAD_BYTE = 8'h36;
    localparam logic [7:0] OPAD_BYTE = 8'h5C;
    localparam logic [31:0] OUTER_LEN_BITS = 32'd672;   // (64 + 20) * 8
    localparam logic [31:0] PAD_MARK = 32'h8000_0000;
    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [2:0] LAST_INDEX = 3'd4;
    localparam logic [6:0] KEY_BYTES = 7'd64;
    localparam logic [5:0] LEN_LIMIT = 6'd56;
    localparam logic [5:0] BLOCK_END = 6'd63;

    localparam logic [4:0][31:0] SHA1_IV = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    typedef logic [31:0] word_t;

    typedef enum logic [1:0] {
        CMD_KEY    = 2'd0,
        CMD_MSG    = 2'd1,
        CMD_FINAL  = 2'd2,
        CMD_FINISH = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        C_IDLE,
        C_PREF,
        C_ROUND,
        C_ADD
    } core_state_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_KEYI,
        S_MSG,
        S_BLK,
        S_PAD,
        S_LEN,
        S_KEYO,
        S_OUTER,
        S_OUT
    } top_state_t;

    typedef struct packed {
        logic start;
        logic use_iv;
    } core_ctl_t;

    typedef struct packed {
        logic       busy;
        logic       done;
        logic [6:0] round;
        logic [3:0] rd_addr;
    } core_stat_t;

endpackage

### design/hse_if.sv
// Valid/ready channel interfaces for the HMAC-SHA1 engine.
// Depends on nothing but plain logic types.
interface hse_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] data_byte;
    modport source (output valid, cmd, data_byte, input ready);
    modport sink (input valid, cmd, data_byte, output ready);
endinterface

interface hse_digest_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

### design/hse_key_store.sv
// Key memory: 16 x 32-bit words, byte assembly and per-word valid bits.
// Depends on hse_pkg.
module hse_key_store (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic               restart,
    input  logic [7:0]         data_byte,
    input  logic [3:0]         rd_addr,
    output hse_pkg::word_t     rd_word
);

    hse_pkg::word_t mem [16];
    hse_pkg::word_t asm_reg, asm_next;
    hse_pkg::word_t rd_data_reg;
    logic           rd_valid_reg;
    logic [6:0]     count_reg, count_next, cnt;
    logic [15:0]    valid_reg, valid_next;
    logic           do_wr;

    always_comb
    begin
        cnt        = restart ? 7'd0 : count_reg;
        valid_next = restart ? 16'd0 : valid_reg;
        count_next = cnt;
        do_wr      = wr_en && (cnt < hse_pkg::KEY_BYTES);
        asm_next   = ((cnt[1:0] == 2'd0) ? 32'd0 : asm_reg)
                   | ({data_byte, 24'd0} >> {cnt[1:0], 3'b000});
        if (do_wr)
        begin
            valid_next[cnt[5:2]] = 1'b1;
            count_next = cnt + 7'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[cnt[5:2]] <= asm_next;
            asm_reg       <= asm_next;
        end
        rd_data_reg  <= mem[rd_addr];
        rd_valid_reg <= valid_reg[rd_addr];
    end

    // never-written words of the key read as zero padding
    assign rd_word = rd_valid_reg ? rd_data_reg : 32'd0;

endmodule

### design/hse_block_store.sv
// Message block memory: 16 x 32-bit words with byte assembly.
// Depends on hse_pkg.
module hse_block_store (
    input  logic           clk,
    input  logic           wr_en,
    input  logic [5:0]     pos,
    input  logic [7:0]     data_byte,
    input  logic [3:0]     rd_addr,
    output hse_pkg::word_t rd_word
);

    hse_pkg::word_t mem [16];
    hse_pkg::word_t asm_reg, asm_next;
    hse_pkg::word_t rd_data_reg;

    assign asm_next = ((pos[1:0] == 2'd0) ? 32'd0 : asm_reg)
                    | ({data_byte, 24'd0} >> {pos[1:0], 3'b000});

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[pos[5:2]] <= asm_next;
            asm_reg       <= asm_next;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_word = rd_data_reg;

endmodule

### design/hse_sha1_core.sv
// SHA-1 compression unit: one round per cycle, 16-word schedule line.
// Depends on hse_pkg and the assertion macro header.
`include "hmac_sha1_engine_top_macros.svh"
module hse_sha1_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  hse_pkg::core_ctl_t    ctl,
    input  hse_pkg::word_t        word_in,
    output hse_pkg::core_stat_t   stat,
    output logic [4:0][31:0]      chain
);

    hse_pkg::core_state_t state_reg, state_next;
    logic [6:0]       t_reg, t_next;
    hse_pkg::word_t   a_reg, b_reg, c_reg, d_reg, e_reg;
    hse_pkg::word_t   sched_reg [16];
    logic [4:0][31:0] chain_reg;
    hse_pkg::word_t   wt, mix, f, k, tmp;

    always_comb
    begin
        mix = sched_reg[13] ^ sched_reg[8] ^ sched_reg[2] ^ sched_reg[0];
        wt  = (t_reg < 7'd16) ? word_in : {mix[30:0], mix[31]};
        if (t_reg < 7'd20)
        begin
            f = (b_reg & c_reg) | (~b_reg & d_reg);
            k = 32'h5A827999;
        end
        else if (t_reg < 7'd40)
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = 32'h6ED9EBA1;
        end
        else if (t_reg < 7'd60)
        begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k = 32'h8F1BBCDC;
        end
        else
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = 32'hCA62C1D6;
        end
        tmp = {a_reg[26:0], a_reg[31:27]} + f + e_reg + k + wt;
    end

    always_comb
    begin
        state_next = state_reg;
        t_next     = t_reg;
        unique case (state_reg)
            hse_pkg::C_IDLE:
                if (ctl.start)
                    state_next = hse_pkg::C_PREF;
            hse_pkg::C_PREF:
            begin
                t_next     = 7'd0;
                state_next = hse_pkg::C_ROUND;
            end
            hse_pkg::C_ROUND:
            begin
                t_next = t_reg + 7'd1;
                if (t_reg == hse_pkg::LAST_ROUND)
                    state_next = hse_pkg::C_ADD;
            end
            hse_pkg::C_ADD:
                state_next = hse_pkg::C_IDLE;
            default:
                state_next = hse_pkg::C_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hse_pkg::C_IDLE;
            t_reg     <= '0;
            chain_reg <= hse_pkg::SHA1_IV;
        end
        else
        begin
            state_reg <= state_next;
            t_reg     <= t_next;
            if (state_reg == hse_pkg::C_IDLE && ctl.start && ctl.use_iv)
                chain_reg <= hse_pkg::SHA1_IV;
            else if (state_reg == hse_pkg::C_ADD)
            begin
                chain_reg[0] <= chain_reg[0] + a_reg;
                chain_reg[1] <= chain_reg[1] + b_reg;
                chain_reg[2] <= chain_reg[2] + c_reg;
                chain_reg[3] <= chain_reg[3] + d_reg;
                chain_reg[4] <= chain_reg[4] + e_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == hse_pkg::C_IDLE && ctl.start)
        begin
            a_reg <= ctl.use_iv ? hse_pkg::SHA1_IV[0] : chain_reg[0];
            b_reg <= ctl.use_iv ? hse_pkg::SHA1_IV[1] : chain_reg[1];
            c_reg <= ctl.use_iv ? hse_pkg::SHA1_IV[2] : chain_reg[2];
            d_reg <= ctl.use_iv ? hse_pkg::SHA1_IV[3] : chain_reg[3];
            e_reg <= ctl.use_iv ? hse_pkg::SHA1_IV[4] : chain_reg[4];
        end
        else if (state_reg == hse_pkg::C_ROUND)
        begin
            a_reg <= tmp;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
            for (int i = 0; i < 15; i++)
                sched_reg[i] <= sched_reg[i + 1];
            sched_reg[15] <= wt;
        end
    end

    // memory read is issued one round ahead
    assign stat.busy    = (state_reg != hse_pkg::C_IDLE);
    assign stat.done    = (state_reg == hse_pkg::C_ADD);
    assign stat.round   = t_reg;
    assign stat.rd_addr = (state_reg == hse_pkg::C_PREF) ? 4'd0 : (t_reg[3:0] + 4'd1);
    assign chain        = chain_reg;

    `HSE_ASSERT_IMP(a_start_when_idle, ctl.start, state_reg == hse_pkg::C_IDLE,
        "core started while busy")
    `HSE_ASSERT_NXT(a_last_round_adds,
        state_reg == hse_pkg::C_ROUND && t_reg == hse_pkg::LAST_ROUND,
        state_reg == hse_pkg::C_ADD, "round 79 not followed by chain add")
    `HSE_ASSERT_IMP(a_round_range, state_reg == hse_pkg::C_ROUND,
        t_reg <= hse_pkg::LAST_ROUND, "round counter out of range")

endmodule

### design/hmac_sha1_engine_top.sv
// Key byte: accepted in idle and stored. Message byte: accepted, then written to the block store; each
// 64th byte also runs a compression (SHA-1 core, one round per cycle, 80 rounds plus prefetch, add and
// launch). Open of a message runs the ipad key compression first. Finish: 3 or 4 compressions, then
// 5 digest words, one per cycle while the receiver is ready. The input is not ready while a byte or a
// compression is in progress, so a new byte is taken only after the last one is through.
// Reset (async, active low) clears control, key valid bits and count; chain returns to IV.
`include "hmac_sha1_engine_top_macros.svh"
module hmac_sha1_engine_top #(
    parameter int LENGTH_COUNTER_BITS = hse_pkg::LCB_DEFAULT
) (
    input logic         clk,
    input logic         rst_n,
    hse_cmd_if.sink     cmd_ch,
    hse_digest_if.source digest_ch
);

    hse_pkg::top_state_t state_reg, state_next;
    logic [LENGTH_COUNTER_BITS-1:0] bc_reg;
    logic [1:0]       cmd_reg;
    logic [7:0]       byte_reg;
    logic             phase_reg, loading_reg, launched_reg;
    logic [4:0][31:0] idig_reg;
    logic [2:0]       idx_reg;
    logic             out_valid_reg, out_last_reg;
    hse_pkg::word_t   out_word_reg;
    logic [2:0]       out_index_reg;

    hse_pkg::core_ctl_t  core_ctl;
    hse_pkg::core_stat_t core_stat;
    logic [4:0][31:0]    chain;
    hse_pkg::word_t      word_in, key_word, blk_word;
    logic                in_acc, key_wr, blk_wr, compute, out_load;
    logic [5:0]          pos;
    logic [3:0]          j;
    logic [63:0]         len64;
    hse_pkg::word_t      keep, mark;

    assign in_acc = cmd_ch.valid && cmd_ch.ready;
    assign cmd_ch.ready = (state_reg == hse_pkg::S_IDLE);
    assign key_wr = in_acc && (cmd_ch.cmd == hse_pkg::CMD_KEY);
    assign pos = bc_reg[5:0];
    assign blk_wr = (state_reg == hse_pkg::S_MSG) && (cmd_reg != hse_pkg::CMD_FINISH);
    assign j = core_stat.round[3:0];
    assign len64 = (64'(bc_reg) + 64'd64) << 3;
    assign out_load = (state_reg == hse_pkg::S_OUT) && (!out_valid_reg || digest_ch.ready);

    assign compute = (state_reg == hse_pkg::S_KEYI) || (state_reg == hse_pkg::S_BLK)
                  || (state_reg == hse_pkg::S_PAD)  || (state_reg == hse_pkg::S_LEN)
                  || (state_reg == hse_pkg::S_KEYO) || (state_reg == hse_pkg::S_OUTER);
    assign core_ctl.start  = compute && !launched_reg;
    assign core_ctl.use_iv = (state_reg == hse_pkg::S_KEYI) || (state_reg == hse_pkg::S_KEYO);

    hse_key_store u_key (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (key_wr),
        .restart   (!loading_reg),
        .data_byte (cmd_ch.data_byte),
        .rd_addr   (core_stat.rd_addr),
        .rd_word   (key_word)
    );

    hse_block_store u_blk (
        .clk       (clk),
        .wr_en     (blk_wr),
        .pos       (pos),
        .data_byte (byte_reg),
        .rd_addr   (core_stat.rd_addr),
        .rd_word   (blk_word)
    );

    hse_sha1_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (core_ctl),
        .word_in (word_in),
        .stat    (core_stat),
        .chain   (chain)
    );

    // word selection for the round unit: padded key, block, padding, length and outer-hash words
    always_comb
    begin
        unique case (pos[1:0])
            2'd0: keep = 32'h0000_0000;
            2'd1: keep = 32'hFF00_0000;
            2'd2: keep = 32'hFFFF_0000;
            2'd3: keep = 32'hFFFF_FF00;
            default: keep = 32'h0000_0000;
        endcase
        mark = hse_pkg::PAD_MARK >> {pos[1:0], 3'b000};
        word_in = 32'd0;
        case (state_reg)
            hse_pkg::S_KEYI:
                word_in = key_word ^ {4{hse_pkg::IPAD_BYTE}};
            hse_pkg::S_KEYO:
                word_in = key_word ^ {4{hse_pkg::OPAD_BYTE}};
            hse_pkg::S_BLK:
                word_in = blk_word;
            hse_pkg::S_PAD:
            begin
                if (j < pos[5:2])
                    word_in = blk_word;
                else if (j == pos[5:2])
                    word_in = (blk_word & keep) | mark;
                else if (pos < hse_pkg::LEN_LIMIT && j == 4'd14)
                    word_in = len64[63:32];
                else if (pos < hse_pkg::LEN_LIMIT && j == 4'd15)
                    word_in = len64[31:0];
            end
            hse_pkg::S_LEN:
            begin
                if (j == 4'd14)
                    word_in = len64[63:32];
                else if (j == 4'd15)
                    word_in = len64[31:0];
            end
            hse_pkg::S_OUTER:
            begin
                if (j < 4'd5)
                    word_in = idig_reg[j[2:0]];
                else if (j == 4'd5)
                    word_in = hse_pkg::PAD_MARK;
                else if (j == 4'd15)
                    word_in = hse_pkg::OUTER_LEN_BITS;
            end
            default:
                word_in = 32'd0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hse_pkg::S_IDLE:
                if (in_acc && cmd_ch.cmd != hse_pkg::CMD_KEY)
                    state_next = phase_reg ? hse_pkg::S_MSG : hse_pkg::S_KEYI;
            hse_pkg::S_KEYI:
                if (core_stat.done)
                    state_next = hse_pkg::S_MSG;
            hse_pkg::S_MSG:
                if (cmd_reg == hse_pkg::CMD_FINISH)
                    state_next = hse_pkg::S_PAD;
                else if (pos == hse_pkg::BLOCK_END)
                    state_next = hse_pkg::S_BLK;
                else if (cmd_reg == hse_pkg::CMD_FINAL)
                    state_next = hse_pkg::S_PAD;
                else
                    state_next = hse_pkg::S_IDLE;
            hse_pkg::S_BLK:
                if (core_stat.done)
                    state_next = (cmd_reg == hse_pkg::CMD_FINAL) ? hse_pkg::S_PAD
                                                                 : hse_pkg::S_IDLE;
            hse_pkg::S_PAD:
                if (core_stat.done)
                    state_next = (pos >= hse_pkg::LEN_LIMIT) ? hse_pkg::S_LEN
                                                             : hse_pkg::S_KEYO;
            hse_pkg::S_LEN:
                if (core_stat.done)
                    state_next = hse_pkg::S_KEYO;
            hse_pkg::S_KEYO:
                if (core_stat.done)
                    state_next = hse_pkg::S_OUTER;
            hse_pkg::S_OUTER:
                if (core_stat.done)
                    state_next = hse_pkg::S_OUT;
            hse_pkg::S_OUT:
                if (out_load && idx_reg == hse_pkg::LAST_INDEX)
                    state_next = hse_pkg::S_IDLE;
            default:
                state_next = hse_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hse_pkg::S_IDLE;
            bc_reg        <= '0;
            phase_reg     <= 1'b0;
            loading_reg   <= 1'b0;
            launched_reg  <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            idig_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (core_stat.done)
                launched_reg <= 1'b0;
            else if (core_ctl.start)
                launched_reg <= 1'b1;

            if (key_wr && !loading_reg)
            begin
                loading_reg <= 1'b1;
                phase_reg   <= 1'b0;
            end
            if (state_reg == hse_pkg::S_KEYI && core_stat.done)
            begin
                phase_reg   <= 1'b1;
                loading_reg <= 1'b0;
                bc_reg      <= '0;
            end
            if (blk_wr)
                bc_reg <= bc_reg + 1'b1;
            // chain holds the inner digest when the outer hash launches
            if (state_reg == hse_pkg::S_KEYO && core_ctl.start)
                idig_reg <= chain;
            if (state_reg == hse_pkg::S_OUTER && core_stat.done)
            begin
                phase_reg   <= 1'b0;
                loading_reg <= 1'b0;
                idx_reg     <= '0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= idx_reg + 3'd1;
            end
            else if (digest_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cmd_reg  <= cmd_ch.cmd;
            byte_reg <= cmd_ch.data_byte;
        end
        if (out_load)
        begin
            out_word_reg  <= chain[idx_reg];
            out_index_reg <= idx_reg;
            out_last_reg  <= (idx_reg == hse_pkg::LAST_INDEX);
        end
    end

    assign digest_ch.valid       = out_valid_reg;
    assign digest_ch.digest_word = out_word_reg;
    assign digest_ch.word_index  = out_index_reg;
    assign digest_ch.last_word   = out_last_reg;

    `HSE_ASSERT_IMP(a_last_is_four, digest_ch.valid && digest_ch.last_word,
        digest_ch.word_index == hse_pkg::LAST_INDEX, "last word not at index four")
    `HSE_ASSERT_IMP(a_no_launch_busy, core_ctl.start, !core_stat.busy,
        "compression launched while core busy")
    `HSE_ASSERT_IMP(a_done_in_compute, core_stat.done, compute,
        "core finished outside a compression state")

endmodule

### tb/hmac_sha1_engine_top_test.sv
// Self-checking bench for the HMAC-SHA1 engine: drives key and message words, predicts digests.
// Depends on hse_pkg, the hse_if interfaces and hmac_sha1_engine_top.
module hmac_sha1_engine_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import hse_pkg::*;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data_byte;
    } cmd_word_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    hse_cmd_if    cmd_ch ();
    hse_digest_if digest_ch ();

    hmac_sha1_engine_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_ch    (cmd_ch.sink),
        .digest_ch (digest_ch.source)
    );

    always #1 clk = ~clk;

    cmd_word_t    pending_words[$];
    digest_word_t digest_queue[$];
    int           error_count = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           hold_cycles = 0;
    bit           stim_done = 1'b0;
    bit           in_taken = 1'b0;

    // predictor state
    logic [7:0]  hk_key[64];
    int          hk_count;
    bit          hk_loading;
    logic [31:0] hk_chain[5];
    logic [31:0] hk_block[16];
    logic [31:0] hk_len;
    bit          hk_open;

    function automatic logic [31:0] rotl(logic [31:0] x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void sha1_compress();
        logic [31:0] w[80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++) w[i] = hk_block[i];
        for (int i = 16; i < 80; i++) w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        a = hk_chain[0]; b = hk_chain[1]; c = hk_chain[2]; d = hk_chain[3]; e = hk_chain[4];
        for (int i = 0; i < 80; i++)
        begin
            if (i < 20)
            begin
                f = (b & c) | (~b & d); k = 32'h5A827999;
            end
            else if (i < 40)
            begin
                f = b ^ c ^ d; k = 32'h6ED9EBA1;
            end
            else if (i < 60)
            begin
                f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
            end
            else
            begin
                f = b ^ c ^ d; k = 32'hCA62C1D6;
            end
            t = rotl(a, 5) + f + e + k + w[i];
            e = d; d = c; c = rotl(b, 30); b = a; a = t;
        end
        hk_chain[0] += a; hk_chain[1] += b; hk_chain[2] += c;
        hk_chain[3] += d; hk_chain[4] += e;
    endfunction

    function automatic void key_block(logic [7:0] pad);
        for (int i = 0; i < 5; i++) hk_chain[i] = SHA1_IV[i];
        for (int i = 0; i < 16; i++)
            hk_block[i] = {hk_key[4*i], hk_key[4*i+1], hk_key[4*i+2], hk_key[4*i+3]}
                          ^ {4{pad}};
        sha1_compress();
    endfunction

    function automatic void put_byte(int pos, logic [7:0] v);
        hk_block[pos / 4][(3 - pos % 4) * 8 +: 8] = v;
    endfunction

    function automatic void close_digest();
        int pos;
        logic [63:0] bits;
        logic [31:0] inner[5];
        pos = hk_len % 64;
        bits = ({32'd0, hk_len} + 64) * 8;
        put_byte(pos, 8'h80);
        for (int i = pos + 1; i < 64; i++) put_byte(i, 8'h00);
        if (pos >= LEN_LIMIT)
        begin
            sha1_compress();
            for (int i = 0; i < 16; i++) hk_block[i] = '0;
        end
        hk_block[14] = bits[63:32];
        hk_block[15] = bits[31:0];
        sha1_compress();
        for (int i = 0; i < 5; i++) inner[i] = hk_chain[i];
        key_block(OPAD_BYTE);
        for (int i = 0; i < 16; i++) hk_block[i] = '0;
        for (int i = 0; i < 5; i++) hk_block[i] = inner[i];
        hk_block[5] = PAD_MARK;
        hk_block[15] = OUTER_LEN_BITS;
        sha1_compress();
        for (int i = 0; i < 5; i++)
            digest_queue.push_back({hk_chain[i], 3'(i), i == LAST_INDEX});
        hk_open = 1'b0;
        hk_loading = 1'b0;
    endfunction

    function automatic void predict_word(cmd_word_t w);
        if (cmd_t'(w.cmd) == CMD_KEY)
        begin
            if (!hk_loading)
            begin
                for (int i = 0; i < 64; i++) hk_key[i] = '0;
                hk_count = 0;
                hk_open = 1'b0;
                hk_loading = 1'b1;
            end
            if (hk_count < KEY_BYTES)
            begin
                hk_key[hk_count] = w.data_byte;
                hk_count++;
            end
            return;
        end
        if (!hk_open)
        begin
            key_block(IPAD_BYTE);
            hk_len = '0;
            hk_open = 1'b1;
            hk_loading = 1'b0;
        end
        if (cmd_t'(w.cmd) == CMD_FINISH)
        begin
            close_digest();
            return;
        end
        put_byte(hk_len % 64, w.data_byte);
        hk_len++;
        if (hk_len % 64 == 0) sha1_compress();
        if (cmd_t'(w.cmd) == CMD_FINAL) close_digest();
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // driver
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
            cmd_ch.cmd <= '0;
            cmd_ch.data_byte <= '0;
        end
        else if (!cmd_ch.valid || in_taken)
        begin
            // a word accepted at the last rising edge is popped here
            if (in_taken)
                void'(pending_words.pop_front());
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                cmd_ch.valid <= 1'b1;
                cmd_ch.cmd <= pending_words[0].cmd;
                cmd_ch.data_byte <= pending_words[0].data_byte;
            end
            else
                cmd_ch.valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        in_taken <= rst_n && cmd_ch.valid && cmd_ch.ready;
        if (rst_n && cmd_ch.valid && cmd_ch.ready)
            predict_word({cmd_ch.cmd, cmd_ch.data_byte});
    end

    // receiver hold-off, counted in its own process
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            digest_ch.ready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            digest_ch.ready <= 1'b0;
        end
        else
            digest_ch.ready <= $urandom_range(99) >= recv_stall_pct;
    end

    // monitor
    always @(posedge clk)
    begin
        digest_word_t exp_w;
        if (rst_n && digest_ch.valid && digest_ch.ready)
        begin
            if (digest_queue.size() == 0)
            begin
                report_mismatch("unexpected word", digest_ch.digest_word, 0);
            end
            else
            begin
                exp_w = digest_queue.pop_front();
                if (digest_ch.digest_word !== exp_w.digest_word)
                    report_mismatch("digest_word", digest_ch.digest_word, exp_w.digest_word);
                if (digest_ch.word_index !== exp_w.word_index)
                    report_mismatch("word_index", digest_ch.word_index, exp_w.word_index);
                if (digest_ch.last_word !== exp_w.last_word)
                    report_mismatch("last_word", digest_ch.last_word, exp_w.last_word);
            end
        end
    end

    function automatic void add_word(cmd_t c, logic [7:0] b);
        pending_words.push_back({c, b});
    endfunction

    function automatic void add_message(int key_len, int msg_len, bit use_final);
        for (int i = 0; i < key_len; i++) add_word(CMD_KEY, 8'($urandom));
        for (int i = 0; i < msg_len; i++)
            add_word((use_final && i == msg_len - 1) ? CMD_FINAL : CMD_MSG, 8'($urandom));
        if (!use_final || msg_len == 0) add_word(CMD_FINISH, 8'($urandom));
    endfunction

    task automatic drain();
        while (pending_words.size() > 0 || cmd_ch.valid || digest_queue.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        int total;
        hk_count = 0;
        hk_loading = 1'b0;
        hk_open = 1'b0;
        hk_len = '0;
        for (int i = 0; i < 64; i++) hk_key[i] = '0;
        for (int i = 0; i < 16; i++) hk_block[i] = '0;
        for (int i = 0; i < 5; i++) hk_chain[i] = SHA1_IV[i];
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty key, empty message, extreme bytes, abandon, long key
        add_word(CMD_FINISH, 8'h00);
        add_word(CMD_KEY, 8'hFF);
        add_word(CMD_KEY, 8'h00);
        add_word(CMD_FINAL, 8'hFF);
        add_word(CMD_MSG, 8'h00);
        add_word(CMD_FINAL, 8'h80);
        add_word(CMD_MSG, 8'h55);
        add_word(CMD_KEY, 8'hAA);          // abandons the open message
        add_word(CMD_MSG, 8'h01);
        add_word(CMD_FINISH, 8'hFF);
        add_message(70, 0, 1'b0);          // bytes past 64 dropped
        drain();

        // random sets; lengths hit block and padding boundaries
        total = 0;
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                3: begin send_idle_pct = 7;  recv_stall_pct = 7;  end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; hold_cycles = 3000; end
            endcase
            while (total < (ph + 1) * 70)
            begin
                int kl, ml;
                kl = ($urandom_range(3) == 0) ? $urandom_range(66) : 0;
                case ($urandom_range(4))
                    0: ml = $urandom_range(3);
                    1: ml = $urandom_range(54, 57);
                    2: ml = $urandom_range(62, 66);
                    3: ml = $urandom_range(118, 122);
                    default: ml = $urandom_range(40);
                endcase
                if ($urandom_range(9) == 0)
                begin
                    add_word(cmd_t'($urandom_range(1, 3)), 8'($urandom)); // stray noise
                    total += 1;
                end
                add_message(kl, ml, $urandom_range(1));
                total += kl + ml + 1;
            end
            drain();
        end
        repeat (50) @(posedge clk);
        stim_done = 1'b1;
    end

    always @(posedge clk)
    begin
        if (stim_done)
        begin
            if (error_count == 0 && digest_queue.size() == 0)
                $display("hmac_sha1_engine_top test passed");
            else
                $display("hmac_sha1_engine_top test failed");
            $finish;
        end
    end

    initial
    begin
        #2000000;
        $display("hmac_sha1_engine_top test failed");
        $finish;
    end
endmodule

### filelist.f
+incdir+design
design/hse_pkg.sv
design/hse_if.sv
design/hse_key_store.sv
design/hse_block_store.sv
design/hse_sha1_core.sv
design/hmac_sha1_engine_top.sv
tb/hmac_sha1_engine_top_test.sv
